>>> src/psurl_pkg.sv
// ----------------------------------------------------------------------------
// psurl_pkg
// shared types, constants and codes of the per-source udp rate limiter
// ----------------------------------------------------------------------------
package psurl_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [15:0] LenEth     = 16'd14;
  localparam logic [15:0] LenEthIpv4 = 16'd34;
  localparam logic [15:0] TypeIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoUdp   = 8'd17;

  localparam logic [2:0] WhyUntracked = 3'd0;
  localparam logic [2:0] WhyCounted   = 3'd1;
  localparam logic [2:0] WhyFresh     = 3'd2;
  localparam logic [2:0] WhyOver      = 3'd3;
  localparam logic [2:0] WhyFull      = 3'd4;

  localparam logic [0:0] RegWindow = 1'd0;
  localparam logic [0:0] RegLimit  = 1'd1;

  localparam logic [39:0] WindowReset = 40'd1000000000;
  localparam logic [7:0]  LimitReset  = 8'd10;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [63:0] arrival_time_ns;
  } pkt_t;

  typedef struct packed {
    logic       drop_packet;
    logic [2:0] decision_reason;
  } verdict_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [63:0] data;
  } cfg_t;

  typedef struct packed {
    logic [31:0] source;
    logic [63:0] window_start;
    logic [7:0]  hits;
  } entry_t;

  // table write request from the controller
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } tbl_wr_t;

endpackage

>>> src/psurl_if.sv
// ----------------------------------------------------------------------------
// psurl_if
// valid/ready channels: packet in, verdict out, configuration writes
// ----------------------------------------------------------------------------
interface psurl_pkt_if;
  logic             valid;
  logic             ready;
  psurl_pkg::pkt_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psurl_verdict_if;
  logic                valid;
  logic                ready;
  psurl_pkg::verdict_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psurl_cfg_if;
  logic            valid;
  logic            ready;
  psurl_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/psurl_table.sv
// ----------------------------------------------------------------------------
// psurl_table
// entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module psurl_table (
  input  logic                            clk,
  input  logic [psurl_pkg::IdxW-1:0]      rd_addr,
  output psurl_pkg::entry_t               rd_data,
  input  psurl_pkg::tbl_wr_t              wr
);

  psurl_pkg::entry_t mem [psurl_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/psurl_ctrl.sv
// ----------------------------------------------------------------------------
// psurl_ctrl
// linear search of the filled entries, read-modify-write of the match or append of a new source
// ----------------------------------------------------------------------------
module psurl_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  psurl_pkt_if.sink                   pkt,
  psurl_verdict_if.source             vrd,
  input  logic [39:0]                 window_length_ns,
  input  logic [7:0]                  packets_per_window,
  output logic [psurl_pkg::IdxW-1:0]  rd_addr,
  input  psurl_pkg::entry_t           rd_data,
  output psurl_pkg::tbl_wr_t          wr
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0]                 state, state_next;
  psurl_pkg::pkt_t            cur;
  logic [psurl_pkg::CntW-1:0] in_use;
  logic [psurl_pkg::CntW-1:0] probe;
  logic                       out_valid;
  psurl_pkg::verdict_t        out_data;
  logic                       tracked;
  logic                       hit;
  logic [63:0]                age;
  logic                       probe_last;

  assign tracked = (pkt.data.frame_length >= psurl_pkg::LenEthIpv4) &&
                   (pkt.data.ether_type == psurl_pkg::TypeIpv4) &&
                   (pkt.data.ip_protocol == psurl_pkg::ProtoUdp);
  assign hit = (rd_data.source == cur.source_address);
  assign age = cur.arrival_time_ns - rd_data.window_start;
  assign probe_last = (probe + 1'b1 >= in_use);
  assign rd_addr = probe[psurl_pkg::IdxW-1:0];

  assign pkt.ready = (state == StIdle) && !out_valid;
  assign vrd.valid = out_valid;
  assign vrd.data  = out_data;

  always_comb begin
    state_next = state;
    unique case (state)
      StIdle: if (pkt.valid && pkt.ready && tracked) begin
        state_next = (in_use == '0) ? StOut : StRead;
      end
      StRead: state_next = StCmp;
      StCmp:  state_next = (hit || probe_last) ? StIdle : StRead;
      StOut:  state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      in_use    <= '0;
      out_valid <= 1'b0;
      probe     <= '0;
      wr.en     <= 1'b0;
    end else begin
      state <= state_next;
      if (vrd.valid && vrd.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          wr.en <= 1'b0;
          if (pkt.valid && pkt.ready) begin
            cur   <= pkt.data;
            probe <= '0;
            if (!tracked) begin
              out_valid <= 1'b1;
              out_data  <= '{1'b0, psurl_pkg::WhyUntracked};
            end
          end
        end
        StRead: wr.en <= 1'b0;
        StCmp: begin
          if (hit) begin
            out_valid <= 1'b1;
            if (age < {24'd0, window_length_ns}) begin
              if (rd_data.hits >= packets_per_window) begin
                out_data <= '{1'b1, psurl_pkg::WhyOver};
                wr.en    <= 1'b0;
              end else begin
                out_data  <= '{1'b0, psurl_pkg::WhyCounted};
                wr.en     <= 1'b1;
                wr.addr   <= probe[psurl_pkg::IdxW-1:0];
                wr.data   <= '{rd_data.source, rd_data.window_start,
                               rd_data.hits + 8'd1};
              end
            end else begin
              out_data <= '{1'b0, psurl_pkg::WhyFresh};
              wr.en    <= 1'b1;
              wr.addr  <= probe[psurl_pkg::IdxW-1:0];
              wr.data  <= '{rd_data.source, cur.arrival_time_ns, 8'd1};
            end
          end else if (probe_last) begin
            out_valid <= 1'b1;
            if (in_use >= psurl_pkg::CntW'(psurl_pkg::TableEntries)) begin
              out_data <= '{1'b1, psurl_pkg::WhyFull};
              wr.en    <= 1'b0;
            end else begin
              out_data <= '{1'b0, psurl_pkg::WhyFresh};
              wr.en    <= 1'b1;
              wr.addr  <= in_use[psurl_pkg::IdxW-1:0];
              wr.data  <= '{cur.source_address, cur.arrival_time_ns, 8'd1};
              in_use   <= in_use + 1'b1;
            end
          end else begin
            wr.en <= 1'b0;
            probe <= probe + 1'b1;
          end
        end
        StOut: begin
          out_valid <= 1'b1;
          out_data  <= '{1'b0, psurl_pkg::WhyFresh};
          wr.en     <= 1'b1;
          wr.addr   <= '0;
          wr.data   <= '{cur.source_address, cur.arrival_time_ns, 8'd1};
          in_use    <= in_use + 1'b1;
        end
        default: wr.en <= 1'b0;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= psurl_pkg::CntW'(psurl_pkg::TableEntries))
    else $error("fill count past table size");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(in_use) |-> $past(wr.en) == 1'b0 && in_use == $past(in_use) + 1'b1)
    else $error("fill count moved by other than one");
  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    state != StIdle |-> !pkt.ready)
    else $error("packet taken during search");

endmodule

>>> src/per_source_udp_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_udp_rate_limiter
// fixed-window packet limiter keyed by ipv4 source, udp only
// ----------------------------------------------------------------------------
// channel   dir  word
// pkt       in   frame_length, ether_type, ip_protocol, source_address, time
// vrd       out  drop_packet, decision_reason
// cfg       in   index (0 window_length_ns, 1 packets_per_window), data
//
// an untracked packet gives its verdict the cycle after it is taken
// a udp packet steps through a registered memory read, then a compare, for each
// entry compared; an empty table goes straight to the output state; a miss compares every filled entry
// the next packet waits until the verdict word has been taken
// synchronous reset empties the table via the fill count, no clearing pass
// ----------------------------------------------------------------------------
module per_source_udp_rate_limiter (
  input  logic             clk,
  input  logic             rst,
  psurl_pkt_if.sink        pkt,
  psurl_verdict_if.source  vrd,
  psurl_cfg_if.sink        cfg
);

  logic [39:0]                       window_length_ns;
  logic [7:0]                        packets_per_window;
  logic [psurl_pkg::IdxW-1:0]        rd_addr;
  psurl_pkg::entry_t                 rd_data;
  psurl_pkg::tbl_wr_t                wr;

  // config registers, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length_ns   <= psurl_pkg::WindowReset;
      packets_per_window <= psurl_pkg::LimitReset;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        psurl_pkg::RegWindow: window_length_ns   <= cfg.data.data[39:0];
        psurl_pkg::RegLimit:  packets_per_window <= cfg.data.data[7:0];
        default: ;
      endcase
    end
  end

  // search and update sequencer
  psurl_ctrl u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .pkt                (pkt),
    .vrd                (vrd),
    .window_length_ns   (window_length_ns),
    .packets_per_window (packets_per_window),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .wr                 (wr)
  );

  // entry store
  psurl_table u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

endmodule

>>> verif/tb_per_source_udp_rate_limiter.sv
// ----------------------------------------------------------------------------
// tb_per_source_udp_rate_limiter
// self-checking bench: directed header and table-path cases, then random udp traffic over a
// small source pool under several window/limit settings and idling phases
// ----------------------------------------------------------------------------
module tb_per_source_udp_rate_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  // running copy of the limiter and the queue of verdicts still owed
  class rate_scoreboard;
    logic [39:0]         window;
    logic [7:0]          limit;
    bit                  used [psurl_pkg::TableEntries];
    logic [31:0]         src [psurl_pkg::TableEntries];
    logic [63:0]         start [psurl_pkg::TableEntries];
    logic [7:0]          cnt [psurl_pkg::TableEntries];
    int unsigned         in_use;
    psurl_pkg::verdict_t verdicts_due [$];
    int                  errors;

    function new();
      window = psurl_pkg::WindowReset;
      limit  = psurl_pkg::LimitReset;
      in_use = 0;
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [63:0] val);
      if (idx == psurl_pkg::RegWindow) window = val[39:0];
      else limit = val[7:0];
    endfunction

    function void note_packet(psurl_pkg::pkt_t p);
      psurl_pkg::verdict_t v;
      int                  hit;
      logic [63:0]         age;
      v.drop_packet     = 1'b0;
      v.decision_reason = psurl_pkg::WhyUntracked;
      hit = -1;
      if (p.frame_length >= psurl_pkg::LenEthIpv4 &&
          p.ether_type == psurl_pkg::TypeIpv4 &&
          p.ip_protocol == psurl_pkg::ProtoUdp) begin
        for (int i = 0; i < in_use; i++) begin
          if (used[i] && src[i] == p.source_address) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          age = p.arrival_time_ns - start[hit];
          if (age < {24'd0, window}) begin
            if (cnt[hit] >= limit) begin
              v.drop_packet     = 1'b1;
              v.decision_reason = psurl_pkg::WhyOver;
            end else begin
              cnt[hit]++;
              v.decision_reason = psurl_pkg::WhyCounted;
            end
          end else begin
            start[hit] = p.arrival_time_ns;
            cnt[hit]   = 8'd1;
            v.decision_reason = psurl_pkg::WhyFresh;
          end
        end else if (in_use >= psurl_pkg::TableEntries) begin
          v.drop_packet     = 1'b1;
          v.decision_reason = psurl_pkg::WhyFull;
        end else begin
          used[in_use]  = 1;
          src[in_use]   = p.source_address;
          start[in_use] = p.arrival_time_ns;
          cnt[in_use]   = 8'd1;
          in_use++;
          v.decision_reason = psurl_pkg::WhyFresh;
        end
      end
      verdicts_due.push_back(v);
    endfunction

    function void check_verdict(psurl_pkg::verdict_t got);
      psurl_pkg::verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict with none expected: drop %0d reason %0d",
               got.drop_packet, got.decision_reason);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got.drop_packet !== want.drop_packet) begin
        $error("drop_packet: expected %0d, got %0d", want.drop_packet, got.drop_packet);
        errors++;
      end
      if (got.decision_reason !== want.decision_reason) begin
        $error("decision_reason: expected %0d, got %0d",
               want.decision_reason, got.decision_reason);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  psurl_pkt_if     pkt_ch ();
  psurl_verdict_if vrd_ch ();
  psurl_cfg_if     cfg_ch ();

  per_source_udp_rate_limiter dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_ch),
    .vrd (vrd_ch),
    .cfg (cfg_ch)
  );

  rate_scoreboard sb = new();

  // idling knobs, percent of cycles
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  logic [31:0] src_pool [16];
  logic [63:0] clock_ns;
  longint      cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // inputs known from time zero
  initial begin
    pkt_ch.valid = 1'b0;
    pkt_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    vrd_ch.ready = 1'b0;
  end

  // receiver side: random back-pressure, one assignment per edge
  always @(posedge clk) begin
    vrd_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitors sample pre-edge values, so no race with the block's updates
  always @(posedge clk) begin
    if (!rst && pkt_ch.valid && pkt_ch.ready) sb.note_packet(pkt_ch.data);
    if (!rst && vrd_ch.valid && vrd_ch.ready) sb.check_verdict(vrd_ch.data);
  end

  // watchdog: ends a run that hangs and reports it as failed
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one word on the packet channel; valid stays high into the next word
  // unless a gap is taken, so valid only gets one assignment per edge
  task automatic send_pkt(psurl_pkg::pkt_t p);
    while ($urandom_range(99) < gap_pct) begin
      pkt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pkt_ch.valid <= 1'b1;
    pkt_ch.data  <= p;
    do @(posedge clk); while (!pkt_ch.ready);
  endtask

  // lower valid and wait until every owed verdict has come back
  task automatic drain();
    pkt_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.verdicts_due.size() != 0) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic psurl_pkg::pkt_t udp_pkt(logic [31:0] s, logic [63:0] t);
    psurl_pkg::pkt_t p;
    p.frame_length    = 16'($urandom_range(65535, psurl_pkg::LenEthIpv4));
    p.ether_type      = psurl_pkg::TypeIpv4;
    p.ip_protocol     = psurl_pkg::ProtoUdp;
    p.source_address  = s;
    p.arrival_time_ns = t;
    return p;
  endfunction

  function automatic psurl_pkg::pkt_t mk_pkt(logic [15:0] len, logic [15:0] et,
                                             logic [7:0] pr, logic [31:0] s,
                                             logic [63:0] t);
    psurl_pkg::pkt_t p;
    p.frame_length    = len;
    p.ether_type      = et;
    p.ip_protocol     = pr;
    p.source_address  = s;
    p.arrival_time_ns = t;
    return p;
  endfunction

  // mostly well-formed udp from the pool, some header noise, a few new
  // sources, and now and then a wild timestamp (often a step backward)
  function automatic psurl_pkg::pkt_t random_pkt(int unsigned step_max);
    psurl_pkg::pkt_t p;
    int unsigned     r;
    logic [31:0]     s;
    r = $urandom_range(99);
    if ($urandom_range(19) == 0) clock_ns = {$urandom, $urandom};
    else clock_ns += $urandom_range(step_max);
    s = ($urandom_range(49) == 0) ? $urandom : src_pool[$urandom_range(15)];
    p = udp_pkt(s, clock_ns);
    if (r < 5) p.frame_length = 16'($urandom_range(psurl_pkg::LenEthIpv4 - 1));
    else if (r < 10) p.ether_type = 16'($urandom);
    else if (r < 15) p.ip_protocol = 8'($urandom);
    else if (r < 18) p = mk_pkt(16'($urandom), 16'($urandom), 8'($urandom), $urandom,
                                {$urandom, $urandom});
    return p;
  endfunction

  initial begin
    psurl_pkg::pkt_t dir [$];
    logic [39:0]     windows [7];
    logic [7:0]      limits [7];
    int unsigned     steps [7];

    cycles   = 0;
    clock_ns = 64'd0;
    foreach (src_pool[i]) src_pool[i] = $urandom;
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;

    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: header boundaries and the table paths at reset settings
    dir.push_back(mk_pkt(16'd0, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp, 32'd1, 64'd0));
    dir.push_back(mk_pkt(16'(psurl_pkg::LenEth - 16'd1), psurl_pkg::TypeIpv4,
                         psurl_pkg::ProtoUdp, 32'd1, 64'd0));
    dir.push_back(mk_pkt(psurl_pkg::LenEth, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp,
                         32'd1, 64'd0));
    dir.push_back(mk_pkt(16'(psurl_pkg::LenEthIpv4 - 16'd1), psurl_pkg::TypeIpv4,
                         psurl_pkg::ProtoUdp, 32'd1, 64'd0));
    dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, 16'h86DD, psurl_pkg::ProtoUdp,
                         32'd1, 64'd0));
    dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, psurl_pkg::TypeIpv4, 8'd6,
                         32'd1, 64'd0));
    dir.push_back(mk_pkt(16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '1));
    dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp,
                         32'd0, 64'd0));
    dir.push_back(mk_pkt(16'hFFFF, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp,
                         32'd0, 64'd5));
    dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp,
                         32'hFFFF_FFFF, '1));
    dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp,
                         32'hFFFF_FFFF, 64'd0));
    // time going backward from the last packet still counts in the open window
    dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp,
                         32'd0, 64'd3));
    // window elapsed, so the window restarts
    dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, psurl_pkg::TypeIpv4, psurl_pkg::ProtoUdp,
                         32'd0, 64'd1000000003));
    for (int i = 0; i < 11; i++)
      dir.push_back(mk_pkt(psurl_pkg::LenEthIpv4, psurl_pkg::TypeIpv4,
                           psurl_pkg::ProtoUdp, 32'd0, 64'd1000000004 + i));
    foreach (dir[i]) send_pkt(dir[i]);
    drain();

    // random phases: settings paired with a time step that hits them
    windows = '{psurl_pkg::WindowReset, 40'd100, 40'd0, 40'hFF_FFFF_FFFF, 40'd1,
                40'd60, 40'd5000};
    limits  = '{psurl_pkg::LimitReset, 8'd3, 8'd5, 8'd255, 8'd1, 8'd0, 8'd200};
    steps   = '{20000000, 40, 3, 1000, 2, 30, 100};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(psurl_pkg::RegWindow, {24'd0, windows[ph]});
      write_reg(psurl_pkg::RegLimit, {56'd0, limits[ph]});
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 60; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < 135; n++) send_pkt(random_pkt(steps[ph]));
      drain();
    end
    repeat (50) @(posedge clk);

    if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
